>>> rtl/mrlc_pkg.sv
package mrlc_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 16;
   localparam int STAMP_WIDTH_DEFAULT  = 32;

   localparam int VERSION_WIDTH = 4;
   localparam logic [VERSION_WIDTH-1:0] VERSION_SUPPORTED = 4'h1;
   localparam int BYTE_WIDTH = 8;

   // config register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_CODE   = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_BYTE        = 2'd0,
      OP_HEADER      = 2'd1,
      OP_VERSION_ERR = 2'd2,
      OP_STREAM_END  = 2'd3
   } op_kind_type;

   localparam int KIND_WIDTH = 2;

endpackage

>>> rtl/mrlc_front.sv
module mrlc_front
   import mrlc_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT,
   parameter int STAMP_WIDTH  = STAMP_WIDTH_DEFAULT,
   parameter int ENTRY_WIDTH  = KIND_WIDTH + 1 + LENGTH_WIDTH + STAMP_WIDTH + BYTE_WIDTH
) (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic [VERSION_WIDTH-1:0] req_version,
   input  logic                     req_end_marker,
   input  logic [LENGTH_WIDTH-1:0]  req_block_length,
   input  logic [STAMP_WIDTH-1:0]   req_stamp,
   input  logic [BYTE_WIDTH-1:0]    req_data_byte,
   input  logic [LENGTH_WIDTH-1:0]  end_code,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [ENTRY_WIDTH-1:0]   push_data
);

   op_kind_type kind;

   // header checks in priority order: version, then end of stream
   always_comb begin
      priority if (req_cmd) begin
         kind = OP_BYTE;
      end else if (req_version != VERSION_SUPPORTED) begin
         kind = OP_VERSION_ERR;
      end else if (req_block_length == end_code) begin
         kind = OP_STREAM_END;
      end else begin
         kind = OP_HEADER;
      end
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign push_data  = {kind, req_end_marker, req_block_length, req_stamp, req_data_byte};

endmodule

>>> rtl/mrlc_queue.sv
module mrlc_queue
   import mrlc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/mrlc_back.sv
module mrlc_back
   import mrlc_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT,
   parameter int STAMP_WIDTH  = STAMP_WIDTH_DEFAULT,
   parameter int ENTRY_WIDTH  = KIND_WIDTH + 1 + LENGTH_WIDTH + STAMP_WIDTH + BYTE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic [ENTRY_WIDTH-1:0]  pop_data,
   input  logic [LENGTH_WIDTH-1:0] max_length,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_byte_valid,
   output logic [BYTE_WIDTH-1:0]   rsp_data_out,
   output logic                    rsp_message_done,
   output logic [LENGTH_WIDTH-1:0] rsp_message_length,
   output logic                    rsp_stream_end,
   output logic                    rsp_version_error
);

   localparam int TotalW = LENGTH_WIDTH + 1;
   localparam logic [TotalW-1:0] TotalMax = '1;

   logic [KIND_WIDTH-1:0]   kind_bits;
   op_kind_type             kind;
   logic                    op_end_marker;
   logic [LENGTH_WIDTH-1:0] op_length;
   logic [STAMP_WIDTH-1:0]  op_stamp;
   logic [BYTE_WIDTH-1:0]   op_byte;

   assign {kind_bits, op_end_marker, op_length, op_stamp, op_byte} = pop_data;
   assign kind = op_kind_type'(kind_bits);

   // message state
   logic                    have_first_ff, have_first_in;
   logic [STAMP_WIDTH-1:0]  first_stamp_ff, first_stamp_in;
   logic                    loss_ff, loss_in;
   logic                    overflow_ff, overflow_in;
   logic [TotalW-1:0]       total_ff, total_in;
   logic [LENGTH_WIDTH-1:0] left_ff, left_in;
   logic                    skipping_ff, skipping_in;
   logic                    final_ff, final_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    byte_valid_ff, byte_valid_in;
   logic [BYTE_WIDTH-1:0]   data_out_ff, data_out_in;
   logic                    done_ff, done_in;
   logic [LENGTH_WIDTH-1:0] msg_len_ff, msg_len_in;
   logic                    stream_end_ff, stream_end_in;
   logic                    verr_ff, verr_in;

   logic                    fire;
   logic                    has_result;
   logic                    clear;
   logic                    len_zero;
   logic                    hdr_loss;
   logic                    hdr_overflow;
   logic [TotalW:0]         sum;
   logic [TotalW-1:0]       sat_total;
   logic [LENGTH_WIDTH-1:0] left_dec;
   logic                    byte_done;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = pop_valid && pop_ready;

   assign len_zero  = (op_length == '0);
   assign hdr_loss  = loss_ff || len_zero || (have_first_ff && (op_stamp != first_stamp_ff));
   assign sum       = {1'b0, total_ff} + {2'b00, op_length};
   assign sat_total = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
   assign hdr_overflow = overflow_ff || ((sat_total > {1'b0, max_length}) && !hdr_loss);
   assign left_dec  = left_ff - 1'b1;
   assign byte_done = (left_dec == '0) && final_ff;

   always_comb begin
      have_first_in  = have_first_ff;
      first_stamp_in = first_stamp_ff;
      loss_in        = loss_ff;
      overflow_in    = overflow_ff;
      total_in       = total_ff;
      left_in        = left_ff;
      skipping_in    = skipping_ff;
      final_in       = final_ff;
      has_result     = 1'b0;
      clear          = 1'b0;
      byte_valid_in  = 1'b0;
      data_out_in    = '0;
      done_in        = 1'b0;
      msg_len_in     = '0;
      stream_end_in  = 1'b0;
      verr_in        = 1'b0;
      if (fire) begin
         unique case (kind)
            OP_VERSION_ERR: begin
               has_result = 1'b1;
               verr_in    = 1'b1;
               clear      = 1'b1;
            end
            OP_STREAM_END: begin
               has_result    = 1'b1;
               stream_end_in = 1'b1;
               clear         = 1'b1;
            end
            OP_HEADER: begin
               if (!len_zero && !have_first_ff) begin
                  have_first_in  = 1'b1;
                  first_stamp_in = op_stamp;
               end
               loss_in     = hdr_loss;
               overflow_in = hdr_overflow;
               total_in    = sat_total;
               left_in     = op_length;
               skipping_in = hdr_loss || hdr_overflow;
               final_in    = op_end_marker;
               // an empty last block ends the message at once, always as loss
               if (len_zero && op_end_marker) begin
                  has_result = 1'b1;
                  done_in    = 1'b1;
                  clear      = 1'b1;
               end
            end
            OP_BYTE: begin
               if (left_ff != '0) begin
                  left_in = left_dec;
                  if (!skipping_ff) begin
                     has_result    = 1'b1;
                     byte_valid_in = 1'b1;
                     data_out_in   = op_byte;
                  end
                  if (byte_done) begin
                     has_result = 1'b1;
                     done_in    = 1'b1;
                     clear      = 1'b1;
                     if (!loss_ff && !overflow_ff) begin
                        msg_len_in = total_ff[LENGTH_WIDTH-1:0];
                     end
                  end
               end
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
      if (clear) begin
         have_first_in  = 1'b0;
         first_stamp_in = '0;
         loss_in        = 1'b0;
         overflow_in    = 1'b0;
         total_in       = '0;
         left_in        = '0;
         skipping_in    = 1'b0;
         final_in       = 1'b0;
      end
   end

   always_comb begin
      if (fire && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff  <= 1'b0;
         first_stamp_ff <= '0;
         loss_ff        <= 1'b0;
         overflow_ff    <= 1'b0;
         total_ff       <= '0;
         left_ff        <= '0;
         skipping_ff    <= 1'b0;
         final_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         have_first_ff  <= have_first_in;
         first_stamp_ff <= first_stamp_in;
         loss_ff        <= loss_in;
         overflow_ff    <= overflow_in;
         total_ff       <= total_in;
         left_ff        <= left_in;
         skipping_ff    <= skipping_in;
         final_ff       <= final_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         byte_valid_ff <= byte_valid_in;
         data_out_ff   <= data_out_in;
         done_ff       <= done_in;
         msg_len_ff    <= msg_len_in;
         stream_end_ff <= stream_end_in;
         verr_ff       <= verr_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_valid     = byte_valid_ff;
   assign rsp_data_out       = data_out_ff;
   assign rsp_message_done   = done_ff;
   assign rsp_message_length = msg_len_ff;
   assign rsp_stream_end     = stream_end_ff;
   assign rsp_version_error  = verr_ff;

`ifndef NO_ASSERTIONS
   a_verr_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && verr_ff) |-> (!byte_valid_ff && !done_ff && !stream_end_ff))
      else $error("version error result carries other flags");

   a_len_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (msg_len_ff != '0)) |-> done_ff)
      else $error("message length without message end");

   a_cleared_after_end: assert property (@(posedge clock) disable iff (reset)
      (fire && has_result && (done_in || verr_in || stream_end_in))
      |=> (total_ff == '0 && left_ff == '0 && !have_first_ff && !loss_ff))
      else $error("message state not cleared after message end");

   a_skip_no_byte: assert property (@(posedge clock) disable iff (reset)
      (fire && skipping_ff && kind == OP_BYTE) |-> !byte_valid_in)
      else $error("skipped byte passed on");
`endif

endmodule

>>> rtl/message_reassembly_loss_check.sv
// path to the output, with the queue empty: the queue takes the item at the accepting
// edge, then the result register loads and rsp_valid rises with it
// throughput: one item per cycle while the receiver does not stall; a two-entry queue between the classifier and
// the message state machine lets both sides stall independently
// reset: synchronous; clears message state and queue, config regs go to all ones
module message_reassembly_loss_check
   import mrlc_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT,
   parameter int STAMP_WIDTH  = STAMP_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [LENGTH_WIDTH-1:0]    csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [VERSION_WIDTH-1:0]   req_version,
   input  logic                       req_end_marker,
   input  logic [LENGTH_WIDTH-1:0]    req_block_length,
   input  logic [STAMP_WIDTH-1:0]     req_stamp,
   input  logic [BYTE_WIDTH-1:0]      req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_byte_valid,
   output logic [BYTE_WIDTH-1:0]      rsp_data_out,
   output logic                       rsp_message_done,
   output logic [LENGTH_WIDTH-1:0]    rsp_message_length,
   output logic                       rsp_stream_end,
   output logic                       rsp_version_error
);

   localparam int EntryW = KIND_WIDTH + 1 + LENGTH_WIDTH + STAMP_WIDTH + BYTE_WIDTH;

   logic [LENGTH_WIDTH-1:0] max_length_ff, max_length_in;
   logic [LENGTH_WIDTH-1:0] end_code_ff, end_code_in;

   logic              push_valid, push_ready;
   logic [EntryW-1:0] push_data;
   logic              pop_valid, pop_ready;
   logic [EntryW-1:0] pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      max_length_in = max_length_ff;
      end_code_in   = end_code_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_LENGTH: max_length_in = csr_data;
            CSR_END_CODE:   end_code_in   = csr_data;
            default:        max_length_in = max_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= '1;
         end_code_ff   <= '1;
      end else begin
         max_length_ff <= max_length_in;
         end_code_ff   <= end_code_in;
      end
   end

   mrlc_front #(
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .STAMP_WIDTH  (STAMP_WIDTH),
      .ENTRY_WIDTH  (EntryW)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_version      (req_version),
      .req_end_marker   (req_end_marker),
      .req_block_length (req_block_length),
      .req_stamp        (req_stamp),
      .req_data_byte    (req_data_byte),
      .end_code         (end_code_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   mrlc_queue #(
      .WIDTH (EntryW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mrlc_back #(
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .STAMP_WIDTH  (STAMP_WIDTH),
      .ENTRY_WIDTH  (EntryW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .max_length         (max_length_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_data_out       (rsp_data_out),
      .rsp_message_done   (rsp_message_done),
      .rsp_message_length (rsp_message_length),
      .rsp_stream_end     (rsp_stream_end),
      .rsp_version_error  (rsp_version_error)
   );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb
   import mrlc_pkg::*;
();

   localparam int LEN_W   = LENGTH_WIDTH_DEFAULT;
   localparam int STAMP_W = STAMP_WIDTH_DEFAULT;

   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_BYTE   = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic [VERSION_WIDTH-1:0] version;
      logic                     end_marker;
      logic [LEN_W-1:0]         block_length;
      logic [STAMP_W-1:0]       stamp;
      logic [BYTE_WIDTH-1:0]    data_byte;
   } link_item_type;

   typedef struct packed {
      logic                  byte_valid;
      logic [BYTE_WIDTH-1:0] data_out;
      logic                  message_done;
      logic [LEN_W-1:0]      message_length;
      logic                  stream_end;
      logic                  version_error;
   } reassembly_out_type;

   class reassembly_scoreboard;
      logic [LEN_W-1:0]   max_length;
      logic [LEN_W-1:0]   end_code;
      bit                 have_stamp;
      logic [STAMP_W-1:0] first_stamp;
      bit                 loss_seen;
      bit                 overflow_seen;
      logic [LEN_W:0]     running_total;
      logic [LEN_W-1:0]   bytes_left;
      bit                 skipping;
      bit                 final_block;
      reassembly_out_type pending_outputs[$];
      int                 failures;

      function new();
         max_length = '1;
         end_code   = '1;
         failures   = 0;
         clear_message();
      endfunction

      function void clear_message();
         have_stamp    = 1'b0;
         first_stamp   = '0;
         loss_seen     = 1'b0;
         overflow_seen = 1'b0;
         running_total = '0;
         bytes_left    = '0;
         skipping      = 1'b0;
         final_block   = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [LEN_W-1:0] value);
         case (idx)
            CSR_MAX_LENGTH: max_length = value;
            CSR_END_CODE:   end_code = value;
            default: ;
         endcase
      endfunction

      function void close_message(inout reassembly_out_type res);
         res.message_done   = 1'b1;
         res.message_length = (loss_seen || overflow_seen) ? '0 : running_total[LEN_W-1:0];
         clear_message();
      endfunction

      function string describe(reassembly_out_type r);
         return $sformatf("byte_valid=%0d data=%02h done=%0d length=%0d end=%0d verr=%0d",
                          r.byte_valid, r.data_out, r.message_done, r.message_length,
                          r.stream_end, r.version_error);
      endfunction

      function void note_item(link_item_type it);
         reassembly_out_type res;
         logic [LEN_W+1:0]   sum;
         bit                 emit;
         res  = '0;
         emit = 1'b0;
         if (it.cmd == CMD_HEADER) begin
            if (it.version != VERSION_SUPPORTED) begin
               clear_message();
               res.version_error = 1'b1;
               emit = 1'b1;
            end else if (it.block_length == end_code) begin
               clear_message();
               res.stream_end = 1'b1;
               emit = 1'b1;
            end else begin
               if (it.block_length == '0)
                  loss_seen = 1'b1;
               else if (!have_stamp) begin
                  have_stamp  = 1'b1;
                  first_stamp = it.stamp;
               end else if (it.stamp != first_stamp)
                  loss_seen = 1'b1;
               // total saturates at all ones of its extra-wide register
               sum = running_total + it.block_length;
               running_total = sum[LEN_W+1] ? '1 : sum[LEN_W:0];
               if (running_total > max_length && !overflow_seen && !loss_seen)
                  overflow_seen = 1'b1;
               bytes_left  = it.block_length;
               skipping    = loss_seen || overflow_seen;
               final_block = it.end_marker;
               if (it.block_length == '0 && final_block) begin
                  close_message(res);
                  emit = 1'b1;
               end
            end
         end else if (bytes_left != '0) begin
            bytes_left = bytes_left - 1'b1;
            if (!skipping) begin
               res.byte_valid = 1'b1;
               res.data_out   = it.data_byte;
               emit = 1'b1;
            end
            if (bytes_left == '0 && final_block) begin
               close_message(res);
               emit = 1'b1;
            end
         end
         if (emit)
            pending_outputs.push_back(res);
      endfunction

      function void check_result(reassembly_out_type got);
         reassembly_out_type want;
         if (pending_outputs.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected result %s", $time, describe(got));
            return;
         end
         want = pending_outputs.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result mismatch\n   expected %s\n   actual   %s",
                        $time, describe(want), describe(got));
         end
      endfunction
   endclass

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 210;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [LEN_W-1:0]           csr_data;
   logic                       req_valid;
   logic                       req_ready;
   link_item_type              req_item;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_byte_valid;
   logic [BYTE_WIDTH-1:0]      rsp_data_out;
   logic                       rsp_message_done;
   logic [LEN_W-1:0]           rsp_message_length;
   logic                       rsp_stream_end;
   logic                       rsp_version_error;
   reassembly_out_type         rsp_seen;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   int sent_items     = 0;

   logic [LEN_W-1:0] max_table [PHASES] =
      '{16'd65535, 16'd0, 16'd12, 16'd65535, 16'd20, 16'd0, 16'd30, 16'd8};
   logic [LEN_W-1:0] end_table [PHASES] =
      '{16'd65535, 16'd0, 16'd65535, 16'd0, 16'd5, 16'd3, 16'd7, 16'd65534};

   reassembly_scoreboard board = new();

   message_reassembly_loss_check DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_item.cmd),
      .req_version        (req_item.version),
      .req_end_marker     (req_item.end_marker),
      .req_block_length   (req_item.block_length),
      .req_stamp          (req_item.stamp),
      .req_data_byte      (req_item.data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_data_out       (rsp_data_out),
      .rsp_message_done   (rsp_message_done),
      .rsp_message_length (rsp_message_length),
      .rsp_stream_end     (rsp_stream_end),
      .rsp_version_error  (rsp_version_error)
   );

   assign rsp_seen = {rsp_byte_valid, rsp_data_out, rsp_message_done, rsp_message_length,
                      rsp_stream_end, rsp_version_error};

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_item(req_item);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("message_reassembly_loss_check regression: fail");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic link_item_type any_item(logic cmd);
      link_item_type it;
      it.cmd          = cmd;
      it.version      = VERSION_WIDTH'($urandom);
      it.end_marker   = 1'($urandom);
      it.block_length = LEN_W'($urandom);
      it.stamp        = STAMP_W'($urandom);
      it.data_byte    = BYTE_WIDTH'($urandom);
      return it;
   endfunction

   function automatic link_item_type header(logic [VERSION_WIDTH-1:0] ver, logic last,
                                            logic [LEN_W-1:0] len, logic [STAMP_W-1:0] stamp);
      link_item_type it;
      it = any_item(CMD_HEADER);
      it.version      = ver;
      it.end_marker   = last;
      it.block_length = len;
      it.stamp        = stamp;
      return it;
   endfunction

   function automatic link_item_type payload(logic [BYTE_WIDTH-1:0] value);
      link_item_type it;
      it = any_item(CMD_BYTE);
      it.data_byte = value;
      return it;
   endfunction

   // this task only lowers valid when a gap is taken, so back-to-back items keep it high
   task automatic send_item(input link_item_type it);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [LEN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                 blocks;
      int                 nbytes;
      int                 pick;
      int                 target;
      logic [STAMP_W-1:0] stamp;
      link_item_type      hdr;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MAX_LENGTH;
      csr_data  <= '0;
      rsp_ready <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // plain two-byte message, then a stray byte
      send_item(header(VERSION_SUPPORTED, 1'b1, 16'd2, 32'hFFFF_FFFF));
      send_item(payload(8'h00));
      send_item(payload(8'hFF));
      send_item(payload(8'hA5));
      // bad versions and end of stream
      send_item(header(4'h0, 1'b1, 16'd4, 32'h0));
      send_item(header(4'hF, 1'b0, 16'd4, 32'h0));
      send_item(header(VERSION_SUPPORTED, 1'b0, 16'hFFFF, 32'h0));
      // zero-length final block ends the message at once
      send_item(header(VERSION_SUPPORTED, 1'b1, 16'd0, 32'h55AA_55AA));
      // zero-length block marks loss, the closing byte is skipped
      send_item(header(VERSION_SUPPORTED, 1'b0, 16'd0, 32'h0000_0001));
      send_item(header(VERSION_SUPPORTED, 1'b1, 16'd1, 32'h0000_0001));
      send_item(payload(8'h3C));
      // timestamp change marks loss
      send_item(header(VERSION_SUPPORTED, 1'b0, 16'd1, 32'h1234_5678));
      send_item(payload(8'h5A));
      send_item(header(VERSION_SUPPORTED, 1'b1, 16'd1, 32'h1234_5679));
      send_item(payload(8'hC3));
      // new header cuts the previous block short without loss
      send_item(header(VERSION_SUPPORTED, 1'b0, 16'd3, 32'h0));
      send_item(payload(8'h01));
      send_item(header(VERSION_SUPPORTED, 1'b1, 16'd1, 32'h0));
      send_item(payload(8'h80));
      // overflow, then the total saturates
      send_item(header(VERSION_SUPPORTED, 1'b0, 16'hFFFE, 32'h8000_0000));
      send_item(header(VERSION_SUPPORTED, 1'b0, 16'hFFFE, 32'h8000_0000));
      send_item(header(VERSION_SUPPORTED, 1'b0, 16'hFFFE, 32'h8000_0000));
      send_item(header(VERSION_SUPPORTED, 1'b1, 16'd1, 32'h8000_0000));
      send_item(payload(8'h7E));
      settle();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_MAX_LENGTH, (p == 5) ? LEN_W'($urandom_range(40)) : max_table[p]);
         write_reg(CSR_END_CODE, (p == 5) ? LEN_W'($urandom_range(8, 1)) : end_table[p]);
         csr_valid <= 1'b0;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         target = sent_items + ITEMS_PER_PHASE;
         while (sent_items < target) begin
            if ($urandom_range(99) < 10)
               send_item(any_item(1'($urandom)));
            else begin
               blocks = $urandom_range(4, 1);
               stamp  = STAMP_W'($urandom);
               for (int b = 0; b < blocks; b++) begin
                  hdr = header(VERSION_SUPPORTED, b == blocks - 1,
                               LEN_W'($urandom_range(6, 1)), stamp);
                  pick = $urandom_range(99);
                  if (pick < 8)
                     hdr.block_length = '0;
                  else if (pick < 12)
                     hdr.block_length = board.end_code;
                  else if (pick < 20)
                     hdr.block_length = LEN_W'($urandom);
                  else if (pick < 24)
                     hdr.block_length = LEN_W'($urandom_range(65535, 60000));
                  else if (pick < 36)
                     hdr.block_length = LEN_W'($urandom_range(20, 1));
                  if ($urandom_range(99) < 6)
                     hdr.stamp = STAMP_W'($urandom);
                  if ($urandom_range(99) < 4)
                     hdr.version = VERSION_WIDTH'($urandom);
                  if ($urandom_range(99) < 5)
                     hdr.end_marker = !hdr.end_marker;
                  send_item(hdr);
                  // long blocks only get a few bytes before the next header
                  nbytes = (hdr.block_length > 20) ? $urandom_range(4) : hdr.block_length;
                  pick = $urandom_range(99);
                  if (pick < 8)
                     nbytes = $urandom_range(nbytes);
                  else if (pick < 13)
                     nbytes += $urandom_range(2, 1);
                  repeat (nbytes) send_item(payload(BYTE_WIDTH'($urandom)));
               end
            end
         end
         settle();
      end

      if (board.failures == 0 && board.pending_outputs.size() == 0)
         $display("message_reassembly_loss_check regression: pass");
      else
         $display("message_reassembly_loss_check regression: fail");
      $finish;
   end
endmodule

>>> sim.f
rtl/mrlc_pkg.sv
rtl/mrlc_front.sv
rtl/mrlc_queue.sv
rtl/mrlc_back.sv
rtl/message_reassembly_loss_check.sv
bench/tb.sv
